>>> hw/rtl/scsd_pkg.sv
// scsd_pkg: shared types, constants and helper functions for the setup code
// and salt derivation core. No dependencies.
package scsd_pkg;

  localparam int unsigned SEED_W = 32;
  localparam int unsigned CODE_W = 27;
  localparam int unsigned DISC_W = 12;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned SALT_W = 64;
  localparam int unsigned NUM_BANNED = 12;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] CODE_SPAN  = 32'd89999998;
  localparam logic [CODE_W-1:0] CODE_BASE = 27'd10000000;
  // low words of the 64-bit lcg constants, only the low 32 bits of x are used
  localparam logic [31:0] LCG_MUL_LO = 32'h4C95_7F2D;
  localparam logic [31:0] LCG_ADD_LO = 32'hF767_814F;

  localparam logic [CODE_W-1:0] BANNED_CODES [NUM_BANNED] = '{
    27'd0,        27'd11111111, 27'd22222222, 27'd33333333,
    27'd44444444, 27'd55555555, 27'd66666666, 27'd77777777,
    27'd88888888, 27'd99999999, 27'd12345678, 27'd87654321
  };

  typedef logic [2:0] step_t;

  localparam step_t MAC_LAST  = 3'd5;
  localparam step_t RED_LAST  = 3'd5;
  localparam step_t PRE_LAST  = 3'd3;
  localparam step_t WORD_LAST = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SEED,
    ST_RED,
    ST_CODE,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_PRE,
    ST_WORD,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MAC,
    OP_SEED,
    OP_RED,
    OP_CODE,
    OP_MUL,
    OP_ADD,
    OP_PRE,
    OP_WORD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    step_t  idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic banned;
  } dp_status_t;

  // divisor multiple for one restoring step, largest first
  function automatic logic [31:0] red_divisor(step_t idx);
    logic [31:0] d;
    unique case (idx)
      3'd0:    d = CODE_SPAN << 5;
      3'd1:    d = CODE_SPAN << 4;
      3'd2:    d = CODE_SPAN << 3;
      3'd3:    d = CODE_SPAN << 2;
      3'd4:    d = CODE_SPAN << 1;
      default: d = CODE_SPAN;
    endcase
    return d;
  endfunction

  function automatic logic code_banned(logic [CODE_W-1:0] code);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_BANNED; k++) begin
      if (BANNED_CODES[k] == code) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> hw/rtl/scsd_if.sv
// scsd_req_if / scsd_rsp_if: valid/ready channels of the derivation core
// depends on scsd_pkg for field widths
interface scsd_req_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [scsd_pkg::SEED_W-1:0]     seed_in;
  logic [scsd_pkg::MAC_W-1:0]      mac_address;

  modport source (output valid, output mode, output seed_in, output mac_address,
                  input ready);
  modport sink   (input valid, input mode, input seed_in, input mac_address,
                  output ready);
endinterface

interface scsd_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [scsd_pkg::SEED_W-1:0]     seed_used;
  logic [scsd_pkg::CODE_W-1:0]     passcode;
  logic [scsd_pkg::DISC_W-1:0]     discriminator;
  logic                            still_forbidden;
  logic [scsd_pkg::SALT_W-1:0]     salt_bytes_0_7;
  logic [scsd_pkg::SALT_W-1:0]     salt_bytes_8_15;
  logic [scsd_pkg::SALT_W-1:0]     salt_bytes_16_23;
  logic [scsd_pkg::SALT_W-1:0]     salt_bytes_24_31;

  modport source (output valid, output seed_used, output passcode, output discriminator,
                  output still_forbidden, output salt_bytes_0_7, output salt_bytes_8_15,
                  output salt_bytes_16_23, output salt_bytes_24_31, input ready);
  modport sink   (input valid, input seed_used, input passcode, input discriminator,
                  input still_forbidden, input salt_bytes_0_7, input salt_bytes_8_15,
                  input salt_bytes_16_23, input salt_bytes_24_31, output ready);
endinterface

>>> hw/rtl/scsd_datapath.sv
// scsd_datapath: shared fnv/lcg multiplier, restoring reducer and result registers
// depends on scsd_pkg; driven by scsd_ctrl through dp_cmd_t
module scsd_datapath (
  input  logic                        clk,
  input  scsd_pkg::dp_cmd_t           cmd,
  output scsd_pkg::dp_status_t        status,
  input  logic                        req_mode,
  input  logic [scsd_pkg::SEED_W-1:0] req_seed_in,
  input  logic [scsd_pkg::MAC_W-1:0]  req_mac_address,
  output logic [scsd_pkg::SEED_W-1:0] seed_used,
  output logic [scsd_pkg::CODE_W-1:0] passcode,
  output logic [scsd_pkg::DISC_W-1:0] discriminator,
  output logic                        still_forbidden,
  output logic [scsd_pkg::SALT_W-1:0] salt_bytes_0_7,
  output logic [scsd_pkg::SALT_W-1:0] salt_bytes_8_15,
  output logic [scsd_pkg::SALT_W-1:0] salt_bytes_16_23,
  output logic [scsd_pkg::SALT_W-1:0] salt_bytes_24_31
);

  logic                        mode;
  logic [31:0]                 seed_raw;
  logic [scsd_pkg::MAC_W-1:0]  mac;
  logic [31:0]                 h;
  logic [31:0]                 seed;
  logic [31:0]                 rem;
  logic [scsd_pkg::CODE_W-1:0] code;
  logic [31:0]                 words [8];

  logic [7:0]  hash_byte;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [31:0] prod;
  logic [31:0] divisor;

  // byte fed to the fnv step
  always_comb begin
    hash_byte = 8'h00;
    unique case (cmd.op)
      scsd_pkg::OP_MAC: begin
        unique case (cmd.idx)
          3'd0:    hash_byte = mac[47:40];
          3'd1:    hash_byte = mac[39:32];
          3'd2:    hash_byte = mac[31:24];
          3'd3:    hash_byte = mac[23:16];
          3'd4:    hash_byte = mac[15:8];
          default: hash_byte = mac[7:0];
        endcase
      end
      scsd_pkg::OP_PRE: begin
        unique case (cmd.idx[1:0])
          2'd0:    hash_byte = seed[31:24];
          2'd1:    hash_byte = seed[23:16];
          2'd2:    hash_byte = seed[15:8];
          default: hash_byte = seed[7:0];
        endcase
      end
      scsd_pkg::OP_WORD: hash_byte = {5'd0, cmd.idx};
      default:           hash_byte = 8'h00;
    endcase
  end

  // one multiplier shared by the hash steps and the remix
  always_comb begin
    if (cmd.op == scsd_pkg::OP_MUL) begin
      mul_a = {5'd0, code};
      mul_b = scsd_pkg::LCG_MUL_LO;
    end else begin
      mul_a = h ^ {24'd0, hash_byte};
      mul_b = scsd_pkg::FNV_PRIME;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign prod     = mul_full[31:0];
  assign divisor  = scsd_pkg::red_divisor(cmd.idx);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      scsd_pkg::OP_LOAD: begin
        mode     <= req_mode;
        seed_raw <= req_seed_in;
        mac      <= req_mac_address;
        h        <= scsd_pkg::FNV_BASIS;
      end
      scsd_pkg::OP_MAC: h <= prod;
      scsd_pkg::OP_SEED: begin
        seed <= mode ? h : seed_raw;
        rem  <= mode ? h : seed_raw;
        h    <= scsd_pkg::FNV_BASIS;
      end
      scsd_pkg::OP_RED: begin
        if (rem >= divisor) begin
          rem <= rem - divisor;
        end
      end
      scsd_pkg::OP_CODE: code <= rem[scsd_pkg::CODE_W-1:0] + scsd_pkg::CODE_BASE;
      scsd_pkg::OP_MUL:  rem  <= prod;
      scsd_pkg::OP_ADD:  rem  <= rem + scsd_pkg::LCG_ADD_LO;
      scsd_pkg::OP_PRE:  h    <= prod;
      scsd_pkg::OP_WORD: words[cmd.idx] <= prod;
      default: begin
      end
    endcase
  end

  assign status.mode   = mode;
  assign status.banned = scsd_pkg::code_banned(code);

  assign seed_used        = seed;
  assign passcode         = code;
  assign discriminator    = seed[31:20];
  assign still_forbidden  = status.banned;
  assign salt_bytes_0_7   = {words[0], words[1]};
  assign salt_bytes_8_15  = {words[2], words[3]};
  assign salt_bytes_16_23 = {words[4], words[5]};
  assign salt_bytes_24_31 = {words[6], words[7]};

endmodule

>>> hw/rtl/scsd_ctrl.sv
// scsd_ctrl: sequencing state machine of the derivation core
// depends on scsd_pkg; issues dp_cmd_t to scsd_datapath
module scsd_ctrl #(
  parameter int REMIX_LIMIT = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output scsd_pkg::dp_cmd_t    cmd,
  input  scsd_pkg::dp_status_t status
);

  localparam int TRIES_W = $clog2(REMIX_LIMIT + 2);
  localparam logic [TRIES_W-1:0] TRIES_MAX = TRIES_W'(REMIX_LIMIT);

  scsd_pkg::state_t      state;
  scsd_pkg::state_t      state_next;
  scsd_pkg::step_t       idx;
  scsd_pkg::step_t       idx_next;
  logic [TRIES_W-1:0]    tries;
  logic [TRIES_W-1:0]    tries_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scsd_pkg::ST_IDLE;
      idx   <= '0;
      tries <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      tries <= tries_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    tries_next = tries;
    unique case (state)
      scsd_pkg::ST_IDLE: begin
        idx_next = '0;
        if (req_valid) begin
          state_next = scsd_pkg::ST_MAC;
        end
      end
      scsd_pkg::ST_MAC: begin
        if (!status.mode || idx == scsd_pkg::MAC_LAST) begin
          state_next = scsd_pkg::ST_SEED;
          idx_next   = '0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      scsd_pkg::ST_SEED: begin
        state_next = scsd_pkg::ST_RED;
        idx_next   = '0;
        tries_next = '0;
      end
      scsd_pkg::ST_RED: begin
        if (idx == scsd_pkg::RED_LAST) begin
          state_next = scsd_pkg::ST_CODE;
          idx_next   = '0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      scsd_pkg::ST_CODE:  state_next = scsd_pkg::ST_CHECK;
      scsd_pkg::ST_CHECK: begin
        if (status.banned && tries < TRIES_MAX) begin
          state_next = scsd_pkg::ST_MUL;
          tries_next = tries + 1'b1;
        end else begin
          state_next = scsd_pkg::ST_PRE;
        end
        idx_next = '0;
      end
      scsd_pkg::ST_MUL: state_next = scsd_pkg::ST_ADD;
      scsd_pkg::ST_ADD: begin
        state_next = scsd_pkg::ST_RED;
        idx_next   = '0;
      end
      scsd_pkg::ST_PRE: begin
        if (idx == scsd_pkg::PRE_LAST) begin
          state_next = scsd_pkg::ST_WORD;
          idx_next   = '0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      scsd_pkg::ST_WORD: begin
        if (idx == scsd_pkg::WORD_LAST) begin
          state_next = scsd_pkg::ST_DONE;
          idx_next   = '0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      scsd_pkg::ST_DONE: begin
        if (rsp_ready) begin
          state_next = scsd_pkg::ST_IDLE;
        end
      end
      default: state_next = scsd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd.op    = scsd_pkg::OP_NOP;
    cmd.idx   = idx;
    unique case (state)
      scsd_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = scsd_pkg::OP_LOAD;
        end
      end
      scsd_pkg::ST_MAC: begin
        if (status.mode) begin
          cmd.op = scsd_pkg::OP_MAC;
        end
      end
      scsd_pkg::ST_SEED:  cmd.op = scsd_pkg::OP_SEED;
      scsd_pkg::ST_RED:   cmd.op = scsd_pkg::OP_RED;
      scsd_pkg::ST_CODE:  cmd.op = scsd_pkg::OP_CODE;
      scsd_pkg::ST_CHECK: cmd.op = scsd_pkg::OP_NOP;
      scsd_pkg::ST_MUL:   cmd.op = scsd_pkg::OP_MUL;
      scsd_pkg::ST_ADD:   cmd.op = scsd_pkg::OP_ADD;
      scsd_pkg::ST_PRE:   cmd.op = scsd_pkg::OP_PRE;
      scsd_pkg::ST_WORD:  cmd.op = scsd_pkg::OP_WORD;
      scsd_pkg::ST_DONE:  rsp_valid = 1'b1;
      default:            cmd.op = scsd_pkg::OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/setup_code_and_salt_derivation_core.sv
// setup_code_and_salt_derivation_core: top level of the derivation core
// depends on scsd_pkg, scsd_if, scsd_ctrl and scsd_datapath
//
// usage
//   req channel (valid/ready): mode, seed_in, mac_address. mode bit 0 set
//     hashes the six mac bytes with fnv-1a into the seed, clear takes seed_in.
//   rsp channel (valid/ready): seed, passcode, discriminator, still_forbidden
//     flag and the 32 salt bytes as four 64-bit words.
//   one request at a time: req.ready is high only while the core is idle.
// sequence, from the accepted request to rsp.valid
//   the mac hash steps run only with mode set, and each passcode remix (up to
//   REMIX_LIMIT of them) adds a pass. the shared 32x32 multiplier and the
//   six-step restoring reducer set the order: six hash steps with mode set,
//   six reduce steps, one multiply/add/reduce pass per remix, then four
//   shared seed-byte steps and eight salt word steps.
// reset and stall
//   rst (synchronous) returns the sequencer to idle and drops rsp.valid.
//   the result stays registered and rsp.valid stays high while rsp.ready is
//   low; no new request is taken until the response has been taken.
module setup_code_and_salt_derivation_core #(
  parameter int REMIX_LIMIT = 12
) (
  input  logic       clk,
  input  logic       rst,
  scsd_req_if.sink   req,
  scsd_rsp_if.source rsp
);

  // command and status between sequencer and datapath
  scsd_pkg::dp_cmd_t    cmd;
  scsd_pkg::dp_status_t status;

  scsd_ctrl #(
    .REMIX_LIMIT (REMIX_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // payload registers hold the result while the receiver stalls
  scsd_datapath u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .req_mode         (req.mode),
    .req_seed_in      (req.seed_in),
    .req_mac_address  (req.mac_address),
    .seed_used        (rsp.seed_used),
    .passcode         (rsp.passcode),
    .discriminator    (rsp.discriminator),
    .still_forbidden  (rsp.still_forbidden),
    .salt_bytes_0_7   (rsp.salt_bytes_0_7),
    .salt_bytes_8_15  (rsp.salt_bytes_8_15),
    .salt_bytes_16_23 (rsp.salt_bytes_16_23),
    .salt_bytes_24_31 (rsp.salt_bytes_24_31)
  );

endmodule

>>> hw/rtl/scsd_checker.sv
// scsd_checker: port-level assertions for the derivation core, bound to the top
// depends on scsd_pkg for field widths
module scsd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [scsd_pkg::SEED_W-1:0] seed_used,
  input logic [scsd_pkg::CODE_W-1:0] passcode,
  input logic [scsd_pkg::DISC_W-1:0] discriminator
);

  // a stalled response holds its passcode
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(passcode))
    else $error("response changed while stalled");

  // passcode of a valid response is an eight digit value in range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> passcode >= 27'd10000000 && passcode <= 27'd99999997)
    else $error("passcode out of range");

  // discriminator follows the top seed bits
  a_disc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> discriminator == seed_used[31:20])
    else $error("discriminator mismatch");

  // no request is taken while a response is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request ready while response pending");

  // a request never answers in the next cycle
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("response too early");

endmodule

bind setup_code_and_salt_derivation_core scsd_checker u_scsd_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .seed_used     (rsp.seed_used),
  .passcode      (rsp.passcode),
  .discriminator (rsp.discriminator)
);

>>> test/testbench.sv
// testbench: self-checking bench for setup_code_and_salt_derivation_core
// depends on scsd_pkg, scsd_req_if / scsd_rsp_if and the core itself
// predicts every response and compares it field by field
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // remix rounds allowed in the core, passed down as its parameter
  localparam int REMIX_TRIES = 12;

  // run length and safety limits
  localparam int RANDOM_PER_PHASE = 160;
  localparam int TAIL_CYCLES      = 200;
  localparam int CYCLE_LIMIT      = 1_000_000;

  // fnv-1a and passcode constants, kept apart from the core's package
  localparam logic [31:0] HASH_OFFSET   = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME    = 32'd16777619;
  localparam logic [31:0] PASSCODE_SPAN = 32'd89999998;
  localparam logic [31:0] PASSCODE_BASE = 32'd10000000;
  localparam logic [63:0] MIX_MUL       = 64'd6364136223846793005;
  localparam logic [63:0] MIX_INC       = 64'd1442695040888963407;

  localparam logic [scsd_pkg::CODE_W-1:0] RESERVED_CODES [12] = '{
    27'd0,        27'd11111111, 27'd22222222, 27'd33333333,
    27'd44444444, 27'd55555555, 27'd66666666, 27'd77777777,
    27'd88888888, 27'd99999999, 27'd12345678, 27'd87654321
  };

  // seed offsets that land straight on a reserved passcode
  // (0 and 99999999 sit outside the reduced range and cannot be hit)
  localparam logic [31:0] RESERVED_OFFSETS [10] = '{
    32'd1111111,  32'd12222222, 32'd23333333, 32'd34444444, 32'd45555555,
    32'd56666666, 32'd67777777, 32'd78888888, 32'd2345678,  32'd77654321
  };

  typedef struct packed {
    logic                        mode;
    logic [scsd_pkg::SEED_W-1:0] seed;
    logic [scsd_pkg::MAC_W-1:0]  mac;
  } setup_req_t;

  typedef struct packed {
    logic [scsd_pkg::SEED_W-1:0]      seed;
    logic [scsd_pkg::CODE_W-1:0]      code;
    logic [scsd_pkg::DISC_W-1:0]      disc;
    logic                             forbidden;
    logic [3:0][scsd_pkg::SALT_W-1:0] salt;
  } setup_rsp_t;

  // directed row: request plus the fields that can be typed in by hand
  typedef struct {
    logic                        mode;
    logic [scsd_pkg::SEED_W-1:0] seed;
    logic [scsd_pkg::MAC_W-1:0]  mac;
    bit                          known;
    logic [scsd_pkg::SEED_W-1:0] seed_used;
    logic [scsd_pkg::CODE_W-1:0] code;
    logic [scsd_pkg::DISC_W-1:0] disc;
    logic                        forbidden;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 22;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // seed extremes and the ends of the passcode range
    '{1'b0, 32'h0000_0000, 48'h0, 1'b1, 32'h0000_0000, 27'd10000000, 12'h000, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
      1'b1, 32'hFFFF_FFFF, 27'd74967389, 12'hFFF, 1'b0},
    '{1'b0, 32'd89999997, 48'h0, 1'b1, 32'd89999997, 27'd99999997, 12'h055, 1'b0},
    '{1'b0, 32'd89999998, 48'hFFFF_FFFF_FFFF,
      1'b1, 32'd89999998, 27'd10000000, 12'h055, 1'b0},
    // discriminator edges
    '{1'b0, 32'h000F_FFFF, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'hFFF0_0000, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    // seeds whose first passcode is reserved, so the remix path runs
    '{1'b0, 32'd1111111,  48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd12222222, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd23333333, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd34444444, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd45555555, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd56666666, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd67777777, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd78888888, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd2345678,  48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b0, 32'd77654321, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    // reserved passcode reached after the modulo wraps once
    '{1'b0, 32'd91111109, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    // mac hashing, with seed_in set to something that must be ignored
    '{1'b1, 32'h0000_0000, 48'h0, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b1, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b1, 32'h1234_5678, 48'h0011_2233_4455, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 48'h8000_0000_0001, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0},
    // seed mode with a busy mac field that must be ignored
    '{1'b0, 32'h8000_0000, 48'hAAAA_5555_AAAA, 1'b0, 32'h0, 27'd0, 12'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  scsd_req_if req();
  scsd_rsp_if rsp();

  setup_code_and_salt_derivation_core #(
    .REMIX_LIMIT(REMIX_TRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  setup_rsp_t pending_results [$];
  int         mismatch_count   = 0;
  int         sender_idle_pct  = 0;
  int         receiver_idle_pct = 0;
  int         cycle_count      = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one fnv-1a round: xor the byte in, multiply by the prime, keep 32 bits
  function automatic logic [31:0] hash_byte(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'h0, b}) * HASH_PRIME;
  endfunction

  function automatic logic passcode_reserved(logic [scsd_pkg::CODE_W-1:0] code);
    logic hit;
    hit = 1'b0;
    foreach (RESERVED_CODES[k]) begin
      if (RESERVED_CODES[k] == code) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic setup_rsp_t derive_setup_values(setup_req_t r);
    setup_rsp_t  res;
    logic [31:0] h;
    logic [63:0] x;
    int          tries;
    logic [31:0] words [8];
    // seed: either taken as is or hashed from the six mac bytes, msb first
    if (r.mode) begin
      h = HASH_OFFSET;
      for (int i = 0; i < 6; i++) begin
        h = hash_byte(h, r.mac[47 - 8 * i -: 8]);
      end
      res.seed = h;
    end else begin
      res.seed = r.seed;
    end
    // first reduction, then remix while the passcode is reserved
    res.code = scsd_pkg::CODE_W'((res.seed % PASSCODE_SPAN) + PASSCODE_BASE);
    tries = 0;
    while (passcode_reserved(res.code) && tries < REMIX_TRIES) begin
      x = 64'(res.code) * MIX_MUL + MIX_INC;
      res.code = scsd_pkg::CODE_W'((x[31:0] % PASSCODE_SPAN) + PASSCODE_BASE);
      tries++;
    end
    res.disc = res.seed[31:20];
    res.forbidden = passcode_reserved(res.code);
    // salt word k hashes the big-endian seed bytes followed by k
    for (int k = 0; k < 8; k++) begin
      h = HASH_OFFSET;
      h = hash_byte(h, res.seed[31:24]);
      h = hash_byte(h, res.seed[23:16]);
      h = hash_byte(h, res.seed[15:8]);
      h = hash_byte(h, res.seed[7:0]);
      h = hash_byte(h, 8'(k));
      words[k] = h;
    end
    // even word in the upper half of each 64-bit salt field
    for (int k = 0; k < 4; k++) begin
      res.salt[k] = {words[2 * k], words[2 * k + 1]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random requests
  // ---------------------------------------------------------------------------

  function automatic setup_req_t random_request();
    setup_req_t r;
    int         sel;
    int         k;
    r.mode = 1'b0;
    r.seed = $urandom;
    r.mac  = 48'({$urandom, $urandom});
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: begin
        // plain mac hashing
        r.mode = 1'b1;
      end
      7: begin
        // aim at a reserved passcode, possibly after several modulo wraps
        k = $urandom_range(46);
        r.seed = RESERVED_OFFSETS[$urandom_range(9)] + k * PASSCODE_SPAN;
      end
      8: begin
        // edges of the modulo and of the seed word
        k = $urandom_range(46);
        case ($urandom_range(3))
          0:       r.seed = (k + 1) * PASSCODE_SPAN;
          1:       r.seed = k * PASSCODE_SPAN + PASSCODE_SPAN - 1;
          2:       r.seed = 32'h1 << $urandom_range(31);
          default: r.seed = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
      end
      9: begin
        // mac bytes biased to all zeros or all ones
        r.mode = 1'b1;
        for (int b = 0; b < 6; b++) begin
          case ($urandom_range(2))
            0:       r.mac[8 * b +: 8] = 8'h00;
            1:       r.mac[8 * b +: 8] = 8'hFF;
            default: r.mac[8 * b +: 8] = 8'($urandom);
          endcase
        end
      end
      default: begin
        // plain seed mode with uniform seed
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // optional idle gap, then hold the request until the core takes it;
  // valid stays high on return so back-to-back requests never toggle it
  task automatic issue_request(setup_req_t r, setup_rsp_t expected);
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= r.mode;
    req.seed_in     <= r.seed;
    req.mac_address <= r.mac;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    pending_results.push_back(expected);
  endtask

  // hold off the sender until every outstanding response is back
  task automatic drain_pending();
    req.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // response side: random backpressure and the checker
  // ---------------------------------------------------------------------------

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    setup_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request pending: seed_used 0x%0h", rsp.seed_used);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("seed_used", want.seed, rsp.seed_used);
        check_field("passcode", want.code, rsp.passcode);
        check_field("discriminator", want.disc, rsp.discriminator);
        check_field("still_forbidden", want.forbidden, rsp.still_forbidden);
        check_field("salt_bytes_0_7", want.salt[0], rsp.salt_bytes_0_7);
        check_field("salt_bytes_8_15", want.salt[1], rsp.salt_bytes_8_15);
        check_field("salt_bytes_16_23", want.salt[2], rsp.salt_bytes_16_23);
        check_field("salt_bytes_24_31", want.salt[3], rsp.salt_bytes_24_31);
      end
    end
  end

  // watchdog: far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    setup_req_t r;
    setup_rsp_t expected;
    req.valid       = 1'b0;
    req.mode        = 1'b0;
    req.seed_in     = '0;
    req.mac_address = '0;

    // synchronous reset at start, then released
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // three phases: slow receiver, slow sender, then full speed
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 8;
          receiver_idle_pct = 85;
        end
        1: begin
          sender_idle_pct   = 85;
          receiver_idle_pct = 8;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase

      // sender waits for an empty pipe at each phase boundary
      drain_pending();

      if (phase == 0) begin
        foreach (directed_table[i]) begin
          r.mode = directed_table[i].mode;
          r.seed = directed_table[i].seed;
          r.mac  = directed_table[i].mac;
          expected = derive_setup_values(r);
          // hand-typed values replace the predicted ones where given
          if (directed_table[i].known) begin
            expected.seed      = directed_table[i].seed_used;
            expected.code      = directed_table[i].code;
            expected.disc      = directed_table[i].disc;
            expected.forbidden = directed_table[i].forbidden;
          end
          issue_request(r, expected);
        end
      end

      repeat (RANDOM_PER_PHASE) begin
        r = random_request();
        issue_request(r, derive_setup_values(r));
      end
    end

    // let the last responses drain, then watch for stray ones
    req.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> setup_code_and_salt_derivation_core.f
hw/rtl/scsd_pkg.sv
hw/rtl/scsd_if.sv
hw/rtl/scsd_datapath.sv
hw/rtl/scsd_ctrl.sv
hw/rtl/setup_code_and_salt_derivation_core.sv
hw/rtl/scsd_checker.sv
test/testbench.sv
